// ===== rtl/fcce_pkg.sv =====
// ----------------------------------------------------------------------------
// fcce_pkg: shared types and constants
// Command and status codes, table marks, state encodings and the request and
// response words between the controller and the entry datapath.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_FREE   = 3'd3;
  localparam logic [2:0] CMD_LOAD   = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;
  localparam logic [1:0] ST_LIMIT  = 2'd3;

  localparam logic [1:0] FT_12 = 2'd0;
  localparam logic [1:0] FT_16 = 2'd1;
  localparam logic [1:0] FT_32 = 2'd2;

  localparam logic [1:0] REG_FAT_TYPE      = 2'd0;
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;

  localparam logic [27:0] MARK_BAD     = 28'hFFFFFF7;
  localparam logic [27:0] MARK_EOF_LOW = 28'hFFFFFF8;
  localparam logic [27:0] MARK_EOF     = 28'hFFFFFFF;

  typedef enum logic [1:0] {
    K_RD_ENTRY,
    K_WR_ENTRY,
    K_RD_BYTE,
    K_WR_BYTE
  } op_kind_t;

  typedef struct packed {
    logic        go;
    op_kind_t    kind;
    logic [27:0] idx;
    logic [27:0] wval;
    logic [15:0] baddr;
    logic [7:0]  bdata;
  } ent_req_t;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic [27:0] rval;
  } ent_rsp_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_BWAIT,
    E_READ,
    E_WRITE,
    E_FIN
  } ent_state_t;

  typedef enum logic [4:0] {
    C_IDLE,
    C_START,
    C_GET_W,
    C_SET_W,
    C_LOAD_W,
    C_RDB_W,
    C_WALK_W,
    C_SCAN1,
    C_SCAN1_W,
    C_SCAN2,
    C_SCAN2_W,
    C_FINAL,
    C_FINAL_W,
    C_LINK_W,
    C_EOF_W,
    C_FREE_RD_W,
    C_FREE_WR_W,
    C_RESP
  } ctrl_state_t;

endpackage

// ===== rtl/fcce_entry.sv =====
// ----------------------------------------------------------------------------
// fcce_entry: entry datapath
// Byte store with one registered port, plus a small sequencer that reads and
// writes packed 12, 16 and 32 bit table entries one byte per cycle.
// ----------------------------------------------------------------------------
module fcce_entry #(
  parameter int FAT_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         fat_type,
  input  logic [15:0]        cluster_count,
  input  fcce_pkg::ent_req_t req,
  output fcce_pkg::ent_rsp_t rsp
);

  localparam int AW = $clog2(FAT_BYTES);

  logic [7:0] mem [FAT_BYTES];
  logic [7:0] rdata_r;

  fcce_pkg::ent_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  nbytes_r, nbytes_nxt;
  logic [18:0] off_r, off_nxt;
  logic        odd_r, odd_nxt;
  logic [27:0] wval_r, wval_nxt;
  logic        is_wr_r, is_wr_nxt;
  logic        bad_r, bad_nxt;
  logic        byte_r, byte_nxt;
  logic [7:0]  raw_r [4];
  logic [7:0]  raw_nxt [4];

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [18:0] req_off;
  logic        rd_bad, wr_bad;
  logic [2:0]  cnt_m1;
  logic [7:0]  wb [4];
  logic [15:0] t16;
  logic [11:0] t12;
  logic [27:0] dec;

  function automatic logic [AW-1:0] wrap(input logic [24:0] a);
    logic [24:0] t;
    t = a % 25'(FAT_BYTES);
    return t[AW-1:0];
  endfunction

  always_comb begin
    case (fat_type)
      fcce_pkg::FT_12: req_off = 19'(req.idx[15:0]) + 19'(req.idx[15:1]);
      fcce_pkg::FT_16: req_off = {2'b0, req.idx[15:0], 1'b0};
      default:         req_off = {1'b0, req.idx[15:0], 2'b0};
    endcase
    rd_bad = (req.idx >= {12'b0, cluster_count}) || (fat_type == 2'd3);
    wr_bad = rd_bad || (req.idx <= 28'd1);
  end

  // bytes to write back, merged with the neighbor nibbles just read
  always_comb begin
    t16 = {wval_r[11:0], raw_r[0][3:0]};
    case (fat_type)
      fcce_pkg::FT_12: begin
        if (odd_r) begin
          wb[0] = t16[7:0];
          wb[1] = t16[15:8];
        end else begin
          wb[0] = wval_r[7:0];
          wb[1] = {raw_r[1][7:4], wval_r[11:8]};
        end
      end
      default: begin
        wb[0] = wval_r[7:0];
        wb[1] = wval_r[15:8];
      end
    endcase
    wb[2] = wval_r[23:16];
    wb[3] = {raw_r[3][7:4], wval_r[27:24]};
  end

  always_comb begin
    logic [15:0] r16;
    r16 = {raw_r[1], raw_r[0]};
    t12 = odd_r ? r16[15:4] : r16[11:0];
    case (fat_type)
      fcce_pkg::FT_12: dec = (t12 >= 12'hFF7) ? {16'hFFFF, t12} : {16'h0, t12};
      fcce_pkg::FT_16: dec = (r16 >= 16'hFFF7) ? {12'hFFF, r16} : {12'h0, r16};
      fcce_pkg::FT_32: dec = {raw_r[3][3:0], raw_r[2], raw_r[1], raw_r[0]};
      default:         dec = fcce_pkg::MARK_BAD;
    endcase
  end

  assign rsp.done = (state_r == fcce_pkg::E_FIN);
  assign rsp.ok   = !bad_r;
  assign rsp.rval = bad_r ? fcce_pkg::MARK_BAD : (byte_r ? {20'h0, raw_r[0]} : dec);

  assign cnt_m1 = cnt_r - 3'd1;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    nbytes_nxt = nbytes_r;
    off_nxt    = off_r;
    odd_nxt    = odd_r;
    wval_nxt   = wval_r;
    is_wr_nxt  = is_wr_r;
    bad_nxt    = bad_r;
    byte_nxt   = byte_r;
    for (int i = 0; i < 4; i++) raw_nxt[i] = raw_r[i];
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wrap(25'(off_r) + 25'(cnt_r));
    mem_wdata = wb[cnt_r[1:0]];

    case (state_r)
      fcce_pkg::E_IDLE, fcce_pkg::E_FIN: begin
        state_nxt = fcce_pkg::E_IDLE;
        if (req.go) begin
          off_nxt    = req_off;
          odd_nxt    = req.idx[0];
          wval_nxt   = req.wval;
          nbytes_nxt = (fat_type == fcce_pkg::FT_32) ? 3'd4 : 3'd2;
          cnt_nxt    = 3'd0;
          byte_nxt   = 1'b0;
          bad_nxt    = 1'b0;
          case (req.kind)
            fcce_pkg::K_RD_BYTE: begin
              mem_re    = 1'b1;
              mem_addr  = wrap(25'(req.baddr));
              byte_nxt  = 1'b1;
              state_nxt = fcce_pkg::E_BWAIT;
            end
            fcce_pkg::K_WR_BYTE: begin
              mem_we    = 1'b1;
              mem_addr  = wrap(25'(req.baddr));
              mem_wdata = req.bdata;
              byte_nxt  = 1'b1;
              state_nxt = fcce_pkg::E_FIN;
            end
            fcce_pkg::K_RD_ENTRY: begin
              is_wr_nxt = 1'b0;
              bad_nxt   = rd_bad;
              state_nxt = rd_bad ? fcce_pkg::E_FIN : fcce_pkg::E_READ;
            end
            default: begin
              is_wr_nxt = 1'b1;
              bad_nxt   = wr_bad;
              state_nxt = wr_bad ? fcce_pkg::E_FIN : fcce_pkg::E_READ;
            end
          endcase
        end
      end
      fcce_pkg::E_BWAIT: begin
        raw_nxt[0] = rdata_r;
        state_nxt  = fcce_pkg::E_FIN;
      end
      fcce_pkg::E_READ: begin
        // issue byte cnt while capturing byte cnt-1
        mem_re = (cnt_r < nbytes_r);
        if (cnt_r != 3'd0) raw_nxt[cnt_m1[1:0]] = rdata_r;
        if (cnt_r == nbytes_r) begin
          cnt_nxt   = 3'd0;
          state_nxt = is_wr_r ? fcce_pkg::E_WRITE : fcce_pkg::E_FIN;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      fcce_pkg::E_WRITE: begin
        mem_we = 1'b1;
        if (cnt_r == nbytes_r - 3'd1) state_nxt = fcce_pkg::E_FIN;
        else cnt_nxt = cnt_r + 3'd1;
      end
      default: state_nxt = fcce_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcce_pkg::E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    nbytes_r <= nbytes_nxt;
    off_r    <= off_nxt;
    odd_r    <= odd_nxt;
    wval_r   <= wval_nxt;
    is_wr_r  <= is_wr_nxt;
    bad_r    <= bad_nxt;
    byte_r   <= byte_nxt;
    for (int i = 0; i < 4; i++) raw_r[i] <= raw_nxt[i];
  end

endmodule

// ===== rtl/fcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcce_ctrl: command controller
// Takes a command word; runs get, set, load byte, read byte, append walk and
// scan, and free chain as sequences of entry ops; holds the result register.
// ----------------------------------------------------------------------------
module fcce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [27:0]        in_cluster,
  input  logic [27:0]        in_next_value,
  input  logic [15:0]        in_byte_address,
  input  logic [7:0]         in_byte_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [27:0]        out_value,
  output logic [1:0]         out_status,
  input  logic [1:0]         fat_type,
  input  logic [15:0]        cluster_count,
  output fcce_pkg::ent_req_t req,
  input  fcce_pkg::ent_rsp_t rsp
);

  fcce_pkg::ctrl_state_t state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [27:0] clu_r, clu_nxt;
  logic [27:0] nv_r, nv_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [27:0] here_r, here_nxt;
  logic [27:0] scan_r, scan_nxt;
  logic [27:0] link_r, link_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [27:0] val_r, val_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [27:0] out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic [27:0] cc28;
  logic [16:0] cnt_inc;

  assign cc28       = {12'h0, cluster_count};
  assign in_ready   = (state_r == fcce_pkg::C_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    clu_nxt        = clu_r;
    nv_nxt         = nv_r;
    addr_nxt       = addr_r;
    data_nxt       = data_r;
    here_nxt       = here_r;
    scan_nxt       = scan_r;
    link_nxt       = link_r;
    cnt_nxt        = cnt_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    cnt_inc        = cnt_r + 17'd1;

    req.go    = 1'b0;
    req.kind  = fcce_pkg::K_RD_ENTRY;
    req.idx   = scan_r;
    req.wval  = 28'h0;
    req.baddr = addr_r;
    req.bdata = data_r;

    case (state_r)
      fcce_pkg::C_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          clu_nxt   = in_cluster;
          nv_nxt    = in_next_value;
          addr_nxt  = in_byte_address;
          data_nxt  = in_byte_data;
          state_nxt = fcce_pkg::C_START;
        end
      end
      fcce_pkg::C_START: begin
        val_nxt   = 28'h0;
        st_nxt    = fcce_pkg::ST_OK;
        state_nxt = fcce_pkg::C_RESP;
        req.idx   = clu_r;
        req.wval  = nv_r;
        case (cmd_r)
          fcce_pkg::CMD_GET: begin
            req.go    = 1'b1;
            state_nxt = fcce_pkg::C_GET_W;
          end
          fcce_pkg::CMD_SET: begin
            req.go    = 1'b1;
            req.kind  = fcce_pkg::K_WR_ENTRY;
            state_nxt = fcce_pkg::C_SET_W;
          end
          fcce_pkg::CMD_LOAD: begin
            req.go    = 1'b1;
            req.kind  = fcce_pkg::K_WR_BYTE;
            state_nxt = fcce_pkg::C_LOAD_W;
          end
          fcce_pkg::CMD_READ: begin
            req.go    = 1'b1;
            req.kind  = fcce_pkg::K_RD_BYTE;
            state_nxt = fcce_pkg::C_RDB_W;
          end
          fcce_pkg::CMD_APPEND: begin
            cnt_nxt = 17'd0;
            if (clu_r >= fcce_pkg::MARK_BAD) begin
              val_nxt = fcce_pkg::MARK_BAD;
              st_nxt  = fcce_pkg::ST_BAD;
            end else if (clu_r > 28'd1) begin
              here_nxt  = clu_r;
              req.go    = 1'b1;
              state_nxt = fcce_pkg::C_WALK_W;
            end else begin
              // new chain: scan from cluster 2
              here_nxt  = 28'd1;
              scan_nxt  = 28'd2;
              state_nxt = fcce_pkg::C_SCAN1;
            end
          end
          fcce_pkg::CMD_FREE: begin
            cnt_nxt = 17'd0;
            if (clu_r <= 28'd1 || clu_r >= cc28 || fat_type == 2'd3) begin
              st_nxt = fcce_pkg::ST_BAD;
            end else begin
              here_nxt  = clu_r;
              req.go    = 1'b1;
              state_nxt = fcce_pkg::C_FREE_RD_W;
            end
          end
          default: ;
        endcase
      end
      fcce_pkg::C_GET_W: begin
        if (rsp.done) begin
          val_nxt   = rsp.rval;
          st_nxt    = (rsp.rval == fcce_pkg::MARK_BAD) ? fcce_pkg::ST_BAD : fcce_pkg::ST_OK;
          state_nxt = fcce_pkg::C_RESP;
        end
      end
      fcce_pkg::C_SET_W: begin
        if (rsp.done) begin
          st_nxt    = rsp.ok ? fcce_pkg::ST_OK : fcce_pkg::ST_BAD;
          state_nxt = fcce_pkg::C_RESP;
        end
      end
      fcce_pkg::C_LOAD_W: begin
        if (rsp.done) state_nxt = fcce_pkg::C_RESP;
      end
      fcce_pkg::C_RDB_W: begin
        if (rsp.done) begin
          val_nxt   = rsp.rval;
          state_nxt = fcce_pkg::C_RESP;
        end
      end
      fcce_pkg::C_WALK_W: begin
        if (rsp.done) begin
          if (rsp.rval >= fcce_pkg::MARK_EOF_LOW || rsp.rval <= 28'd1) begin
            scan_nxt  = here_r + 28'd1;
            state_nxt = fcce_pkg::C_SCAN1;
          end else if (rsp.rval == fcce_pkg::MARK_BAD) begin
            val_nxt   = fcce_pkg::MARK_BAD;
            st_nxt    = fcce_pkg::ST_BAD;
            state_nxt = fcce_pkg::C_RESP;
          end else if (cnt_inc >= {1'b0, cluster_count}) begin
            val_nxt   = fcce_pkg::MARK_BAD;
            st_nxt    = fcce_pkg::ST_LIMIT;
            state_nxt = fcce_pkg::C_RESP;
          end else begin
            cnt_nxt  = cnt_inc;
            here_nxt = rsp.rval;
            req.go   = 1'b1;
            req.idx  = rsp.rval;
          end
        end
      end
      fcce_pkg::C_SCAN1: begin
        if (scan_r < cc28) begin
          req.go    = 1'b1;
          state_nxt = fcce_pkg::C_SCAN1_W;
        end else begin
          // wrap around to the start of the table
          scan_nxt  = 28'd2;
          state_nxt = fcce_pkg::C_SCAN2;
        end
      end
      fcce_pkg::C_SCAN1_W: begin
        if (rsp.done) begin
          if (rsp.rval == 28'h0) begin
            state_nxt = fcce_pkg::C_FINAL;
          end else begin
            scan_nxt  = scan_r + 28'd1;
            state_nxt = fcce_pkg::C_SCAN1;
          end
        end
      end
      fcce_pkg::C_SCAN2: begin
        if (scan_r < here_r) begin
          req.go    = 1'b1;
          state_nxt = fcce_pkg::C_SCAN2_W;
        end else begin
          state_nxt = fcce_pkg::C_FINAL;
        end
      end
      fcce_pkg::C_SCAN2_W: begin
        if (rsp.done) begin
          if (rsp.rval == 28'h0) begin
            state_nxt = fcce_pkg::C_FINAL;
          end else begin
            scan_nxt  = scan_r + 28'd1;
            state_nxt = fcce_pkg::C_SCAN2;
          end
        end
      end
      fcce_pkg::C_FINAL: begin
        req.go    = 1'b1;
        state_nxt = fcce_pkg::C_FINAL_W;
      end
      fcce_pkg::C_FINAL_W: begin
        if (rsp.done) begin
          if (rsp.rval != 28'h0) begin
            val_nxt   = fcce_pkg::MARK_BAD;
            st_nxt    = fcce_pkg::ST_NOFREE;
            state_nxt = fcce_pkg::C_RESP;
          end else if (here_r > 28'd1) begin
            req.go    = 1'b1;
            req.kind  = fcce_pkg::K_WR_ENTRY;
            req.idx   = here_r;
            req.wval  = scan_r;
            state_nxt = fcce_pkg::C_LINK_W;
          end else begin
            req.go    = 1'b1;
            req.kind  = fcce_pkg::K_WR_ENTRY;
            req.wval  = fcce_pkg::MARK_EOF;
            state_nxt = fcce_pkg::C_EOF_W;
          end
        end
      end
      fcce_pkg::C_LINK_W: begin
        if (rsp.done) begin
          req.go    = 1'b1;
          req.kind  = fcce_pkg::K_WR_ENTRY;
          req.wval  = fcce_pkg::MARK_EOF;
          state_nxt = fcce_pkg::C_EOF_W;
        end
      end
      fcce_pkg::C_EOF_W: begin
        if (rsp.done) begin
          val_nxt   = scan_r;
          st_nxt    = fcce_pkg::ST_OK;
          state_nxt = fcce_pkg::C_RESP;
        end
      end
      fcce_pkg::C_FREE_RD_W: begin
        if (rsp.done) begin
          link_nxt  = rsp.rval;
          req.go    = 1'b1;
          req.kind  = fcce_pkg::K_WR_ENTRY;
          req.idx   = here_r;
          state_nxt = fcce_pkg::C_FREE_WR_W;
        end
      end
      fcce_pkg::C_FREE_WR_W: begin
        if (rsp.done) begin
          if (!rsp.ok) cnt_inc = cnt_r;
          cnt_nxt = cnt_inc;
          val_nxt = 28'(cnt_inc);
          if (link_r >= fcce_pkg::MARK_BAD || link_r <= 28'd1) begin
            st_nxt    = fcce_pkg::ST_OK;
            state_nxt = fcce_pkg::C_RESP;
          end else if (cnt_inc >= {1'b0, cluster_count}) begin
            st_nxt    = fcce_pkg::ST_LIMIT;
            state_nxt = fcce_pkg::C_RESP;
          end else begin
            here_nxt  = link_r;
            req.go    = 1'b1;
            req.idx   = link_r;
            state_nxt = fcce_pkg::C_FREE_RD_W;
          end
        end
      end
      fcce_pkg::C_RESP: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = val_r;
          out_status_nxt = st_r;
          state_nxt      = fcce_pkg::C_IDLE;
        end
      end
      default: state_nxt = fcce_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcce_pkg::C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    clu_r        <= clu_nxt;
    nv_r         <= nv_nxt;
    addr_r       <= addr_nxt;
    data_r       <= data_nxt;
    here_r       <= here_nxt;
    scan_r       <= scan_nxt;
    link_r       <= link_nxt;
    cnt_r        <= cnt_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/fat_cluster_chain_engine_core.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_core: FAT12/16/32 cluster chain engine
// Command word in, one result word out per command; registers on APB.
// ----------------------------------------------------------------------------
// Usage: program fat_type (0x0) and cluster_count (0x4) over APB while idle,
// fill the table with load-byte commands, then issue get, set, append, free.
// The in_ channel carries one command word; the out_ channel returns one word
// (value, status) per command, in order. One command is in flight at a time.
// Each command works through the single byte port of the store (one byte per
// cycle): load byte writes one byte and read byte reads one; get reads two
// bytes (12/16-bit) or four (32-bit); set reads them, merges and writes back;
// get or set on a refused index touches no byte. Append walks the chain
// links, scans entries for a free one, then writes the link and the end mark
// (only the end mark for a new chain); free reads and clears each entry.
// Next command: taken once the controller is back in idle, which it enters
// as the result word is loaded into the output register.
// Reset: fat_type returns to 1, cluster_count to 0, the result register
// empties; the byte store keeps no reset and must be loaded before use.
// A stalled receiver holds the result in the output register; the next
// command is taken and worked, then waits until that word is taken.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_core #(
  parameter int FAT_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [27:0] in_cluster,
  input  logic [27:0] in_next_value,
  input  logic [15:0] in_byte_address,
  input  logic [7:0]  in_byte_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [27:0] out_value,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  fat_type_r, fat_type_nxt;
  logic [15:0] cluster_count_r, cluster_count_nxt;
  logic [1:0]  reg_idx;

  fcce_pkg::ent_req_t req;
  fcce_pkg::ent_rsp_t rsp;

  assign pready  = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};

  always_comb begin
    fat_type_nxt      = fat_type_r;
    cluster_count_nxt = cluster_count_r;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        fcce_pkg::REG_FAT_TYPE:      fat_type_nxt      = pwdata[1:0];
        fcce_pkg::REG_CLUSTER_COUNT: cluster_count_nxt = pwdata[15:0];
        default: ;
      endcase
    end
    case (reg_idx)
      fcce_pkg::REG_FAT_TYPE:      prdata = {30'h0, fat_type_r};
      fcce_pkg::REG_CLUSTER_COUNT: prdata = {16'h0, cluster_count_r};
      default:                     prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_type_r      <= fcce_pkg::FT_16;
      cluster_count_r <= 16'h0;
    end else begin
      fat_type_r      <= fat_type_nxt;
      cluster_count_r <= cluster_count_nxt;
    end
  end

  fcce_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_cluster      (in_cluster),
    .in_next_value   (in_next_value),
    .in_byte_address (in_byte_address),
    .in_byte_data    (in_byte_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .fat_type        (fat_type_r),
    .cluster_count   (cluster_count_r),
    .req             (req),
    .rsp             (rsp)
  );

  fcce_entry #(.FAT_BYTES(FAT_BYTES)) u_entry (
    .clk           (clk),
    .rst_n         (rst_n),
    .fat_type      (fat_type_r),
    .cluster_count (cluster_count_r),
    .req           (req),
    .rsp           (rsp)
  );

  // one command at a time: ready drops right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in flight");

  // no-free results from append carry the bad mark (walk-limit ones do too, unchecked here)
  a_nofree_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fcce_pkg::ST_NOFREE |-> out_value == fcce_pkg::MARK_BAD)
    else $error("no-free result without bad mark");

  // datapath requests only arrive while a command is being worked
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !in_ready)
    else $error("entry request while idle");

endmodule
